@@ rtl/dsp_pkg.sv @@
// dsp_pkg: shared types and constants of the DNA symbol packer.
// No dependencies; compiled before the interfaces and all modules.
package dsp_pkg;

    // Dense coding: group / tail widths, the saturation limit and the base-5 radix
    localparam logic [2:0] GROUP_BITS  = 3'd7;
    localparam logic [2:0] PAIR_BITS   = 3'd5;
    localparam logic [2:0] SINGLE_BITS = 3'd3;
    localparam logic [3:0] MAX_DENSE_SYM = 4'd4;
    localparam logic [6:0] RADIX_SQ    = 7'd25;
    localparam logic [6:0] RADIX       = 7'd5;

    // Up to two packed bytes leave the packing stage per symbol
    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] byte0;
        logic       last0;
        logic [7:0] byte1;
        logic       last1;
    } push_t;

endpackage

@@ rtl/dsp_ifs.sv @@
// dsp_ifs: valid/ready channel interfaces of the DNA symbol packer.
// Symbol input, packed byte output and the mode register write channel.
interface dsp_sym_if;
    logic       valid;
    logic       ready;
    logic [3:0] symbol;
    logic       last_symbol;
    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface dsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;
    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

interface dsp_cfg_if;
    logic valid;
    logic ready;
    logic dense_mode;
    modport source (output valid, output dense_mode, input ready);
    modport sink   (input valid, input dense_mode, output ready);
endinterface

@@ rtl/dsp_pack_core.sv @@
// dsp_pack_core: input register, mode register and the packing state.
// Depends on dsp_pkg and dsp_ifs; feeds 0..2 bytes per symbol to dsp_out_fifo.
module dsp_pack_core
    import dsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dsp_sym_if.sink       symbols,
    dsp_cfg_if.sink       cfg,
    input  logic          room,
    output push_t         push
);

    logic       s1_valid_reg;
    logic [3:0] s1_sym_reg;
    logic       s1_last_reg;
    logic       dense_mode_reg;
    logic [3:0] first_held_reg,  first_held_next;
    logic [3:0] second_held_reg, second_held_next;
    logic [1:0] held_count_reg,  held_count_next;
    logic [6:0] bit_store_reg,   bit_store_next;
    logic [2:0] bit_count_reg,   bit_count_next;

    logic        advance;
    logic [3:0]  sym;
    logic [6:0]  code7;
    logic [6:0]  code5;
    logic        bits_en;
    logic [6:0]  bits_val;
    logic [2:0]  bits_num;
    logic [13:0] acc;
    logic [3:0]  total;
    logic        full_byte;
    logic [2:0]  rem;
    logic [7:0]  full_val;
    logic [7:0]  pad_val;
    logic [6:0]  store_new;

    assign advance       = s1_valid_reg && room;
    assign symbols.ready = !s1_valid_reg || room;
    assign cfg.ready     = 1'b1;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (symbols.ready)
        begin
            s1_valid_reg <= symbols.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (symbols.valid && symbols.ready)
        begin
            s1_sym_reg  <= symbols.symbol;
            s1_last_reg <= symbols.last_symbol;
        end
    end

    // Saturated symbol and the base-5 codes
    always_comb
    begin
        sym   = (s1_sym_reg > MAX_DENSE_SYM) ? MAX_DENSE_SYM : s1_sym_reg;
        code7 = 7'(first_held_reg) * RADIX_SQ + 7'(second_held_reg) * RADIX + 7'(sym);
        code5 = 5'(first_held_reg) * 5'(RADIX) + 5'(sym) == 5'd0 ? 7'd0
              : 7'(5'(first_held_reg) * 5'(RADIX) + 5'(sym));
    end

    // Dense mode: what goes into the bit packer
    always_comb
    begin
        bits_en  = 1'b0;
        bits_val = code7;
        bits_num = GROUP_BITS;
        if (s1_last_reg)
        begin
            bits_en = 1'b1;
            case (held_count_reg)
                2'd0:    begin bits_val = 7'(sym); bits_num = SINGLE_BITS; end
                2'd1:    begin bits_val = code5;   bits_num = PAIR_BITS;   end
                default: begin bits_val = code7;   bits_num = GROUP_BITS;  end
            endcase
        end
        else if (held_count_reg == 2'd2)
        begin
            bits_en = 1'b1;
        end
    end

    // MSB-first bit packer
    always_comb
    begin
        acc       = (14'(bit_store_reg) << bits_num) | 14'(bits_val);
        total     = 4'(bit_count_reg) + 4'(bits_num);
        full_byte = total >= 4'd8;
        rem       = full_byte ? 3'(total - 4'd8) : total[2:0];
        full_val  = 8'(acc >> rem);
        store_new = 7'(acc & ((14'd1 << rem) - 14'd1));
        pad_val   = {1'b0, store_new} << (4'd8 - 4'(rem));
    end

    // Next state and bytes out
    always_comb
    begin
        first_held_next  = first_held_reg;
        second_held_next = second_held_reg;
        held_count_next  = held_count_reg;
        bit_store_next   = bit_store_reg;
        bit_count_next   = bit_count_reg;
        push             = '0;
        if (dense_mode_reg)
        begin
            if (s1_last_reg)
            begin
                first_held_next  = '0;
                second_held_next = '0;
                held_count_next  = '0;
                bit_store_next   = '0;
                bit_count_next   = '0;
                if (full_byte)
                begin
                    push.byte0 = full_val;
                    push.last0 = (rem == 3'd0);
                    push.byte1 = pad_val;
                    push.last1 = 1'b1;
                    push.cnt   = (rem == 3'd0) ? 2'd1 : 2'd2;
                end
                else if (rem != 3'd0)
                begin
                    push.byte0 = pad_val;
                    push.last0 = 1'b1;
                    push.cnt   = 2'd1;
                end
            end
            else if (bits_en)
            begin
                held_count_next = '0;
                bit_store_next  = store_new;
                bit_count_next  = rem;
                if (full_byte)
                begin
                    push.byte0 = full_val;
                    push.cnt   = 2'd1;
                end
            end
            else if (held_count_reg == 2'd0)
            begin
                first_held_next = sym;
                held_count_next = 2'd1;
            end
            else
            begin
                second_held_next = sym;
                held_count_next  = 2'd2;
            end
        end
        else
        begin
            // Nibble mode: first symbol high, second low
            if (held_count_reg == 2'd0 && !s1_last_reg)
            begin
                first_held_next = s1_sym_reg;
                held_count_next = 2'd1;
            end
            else
            begin
                push.cnt         = 2'd1;
                push.byte0       = (held_count_reg == 2'd0) ? {s1_sym_reg, 4'd0}
                                                            : {first_held_reg, s1_sym_reg};
                push.last0       = s1_last_reg;
                first_held_next  = '0;
                second_held_next = '0;
                held_count_next  = '0;
                bit_store_next   = '0;
                bit_count_next   = '0;
            end
        end
        if (!advance)
        begin
            push.cnt = 2'd0;
        end
    end

    // Mode register and packing state; a mode write clears the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dense_mode_reg  <= 1'b1;
            first_held_reg  <= '0;
            second_held_reg <= '0;
            held_count_reg  <= '0;
            bit_store_reg   <= '0;
            bit_count_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            dense_mode_reg  <= cfg.dense_mode;
            first_held_reg  <= '0;
            second_held_reg <= '0;
            held_count_reg  <= '0;
            bit_store_reg   <= '0;
            bit_count_reg   <= '0;
        end
        else if (advance)
        begin
            first_held_reg  <= first_held_next;
            second_held_reg <= second_held_next;
            held_count_reg  <= held_count_next;
            bit_store_reg   <= bit_store_next;
            bit_count_reg   <= bit_count_next;
        end
    end

`ifndef SYNTHESIS
    a_nibble_one_held: assert property (@(posedge clk) disable iff (!rst_n)
        !dense_mode_reg |-> held_count_reg <= 2'd1)
        else $error("nibble mode holds more than one symbol");
    a_read_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_last_reg && !cfg.valid) |=> (held_count_reg == 2'd0
            && bit_count_reg == 3'd0 && bit_store_reg == 7'd0))
        else $error("packing state left over after end of read");
    a_store_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_store_reg >> bit_count_reg) == 7'd0)
        else $error("stray bits above the pending count");
`endif

endmodule

@@ rtl/dsp_out_fifo.sv @@
// dsp_out_fifo: small byte queue taking up to two bytes per cycle.
// Depends on dsp_pkg and dsp_ifs; drives the packed byte channel.
module dsp_out_fifo
    import dsp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  push_t         push,
    output logic          room,
    dsp_byte_if.source    packed_bytes
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [7:0]    mem_byte [DEPTH];
    logic          mem_last [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next, wr_ptr_inc;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic          pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    assign room               = count_reg <= CW'(DEPTH - 2);
    assign pop                = packed_bytes.valid && packed_bytes.ready;
    assign packed_bytes.valid = count_reg != '0;
    assign packed_bytes.out_byte  = mem_byte[rd_ptr_reg];
    assign packed_bytes.last_byte = mem_last[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_inc  = ptr_inc(wr_ptr_reg);
        wr_ptr_next = wr_ptr_reg;
        case (push.cnt)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage writes: first byte at wr_ptr, second right after it
    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            mem_byte[wr_ptr_reg] <= push.byte0;
            mem_last[wr_ptr_reg] <= push.last0;
        end
        if (push.cnt == 2'd2)
        begin
            mem_byte[wr_ptr_inc] <= push.byte1;
            mem_last[wr_ptr_inc] <= push.last1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> room)
        else $error("byte queue written without room");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("byte queue count beyond depth");
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt == 2'd0 && !pop) |=> $stable(count_reg) && $stable(rd_ptr_reg))
        else $error("byte queue moved without a request");
`endif

endmodule

@@ rtl/dna_symbol_packer.sv @@
// dna_symbol_packer: top level; packs nucleotide symbols into bytes.
// Depends on dsp_pkg, dsp_ifs, dsp_pack_core and dsp_out_fifo.
//
//   channel       dir  request contents
//   symbols       in   symbol[3:0], last_symbol
//   packed_bytes  out  out_byte[7:0], last_byte
//   cfg           in   dense_mode (write clears packing state)
//
// One symbol request per cycle while the queue has room; its bytes pass
// through the input register into the output queue and leave it from there.
// A symbol yields zero, one or two bytes; the queue (FIFO_DEPTH entries)
// takes a new symbol while it has room for two more bytes.
// Output stalls back up into the input register and then symbols.ready.
// Reset: dense mode, empty queue, no held symbols or pending bits.
module dna_symbol_packer
    import dsp_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    dsp_sym_if.sink       symbols,
    dsp_byte_if.source    packed_bytes,
    dsp_cfg_if.sink       cfg
);

    push_t push;
    logic  room;

    dsp_pack_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .symbols (symbols),
        .cfg     (cfg),
        .room    (room),
        .push    (push)
    );

    dsp_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .packed_bytes (packed_bytes)
    );

endmodule
